@@ sv/lsfe_pkg.sv @@
// lsfe_pkg: shared types, codes, constants and helper functions of the
// LIN slave frame engine. No dependencies; used by every other file.
package lsfe_pkg;

    // Field widths
    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;
    localparam int ID_W     = 6;
    localparam int LEN_W    = 4;
    localparam int KIND_W   = 3;
    localparam int BAUD_W   = 15;

    // Response length limit
    localparam logic [LEN_W-1:0] MAX_DATA_BYTES = 4'd8;

    // Timeout arithmetic: limit = TO_BASE + len * LEN_SCALE / baud, capped
    localparam int NUM_W = 17;
    localparam int TICK_W = 7;
    localparam logic [NUM_W-1:0]  LEN_SCALE = 17'd10000;
    localparam logic [TICK_W-1:0] TO_BASE   = 7'd5;
    localparam logic [TICK_W-1:0] TO_MAX    = 7'd127;
    localparam logic [BAUD_W-1:0] BAUD_RESET = 15'd19200;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] ID_MASK   = 8'h3F;
    localparam logic [BYTE_W-1:0] SUM_MOD   = 8'hFF;

    // Input opcodes
    localparam logic [OPCODE_W-1:0] OP_BUS_BYTE = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_ARM_RX   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ARM_TX   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TX_DATA  = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER_ID = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RX_DATA   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME_OK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CHK_BAD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TX_BYTE   = 3'd5;

    // Source of the result value register
    typedef enum logic [1:0] {
        VAL_ID,
        VAL_BYTE,
        VAL_CHK,
        VAL_ZERO
    } t_val_sel;

    // Controller to datapath
    typedef struct packed {
        logic     hunt_set;   // sync byte seen
        logic     hunt_clr;   // header id consumed
        logic     arm;        // seed checksum, load length, clear counters
        logic     div_start;  // start timeout limit division
        logic     add_byte;   // accumulate data byte, bump count
        logic     tick;       // advance elapsed ticks
        logic     out_load;   // load result value register
        t_val_sel out_sel;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sync_seen;
        logic byte_is_sync;
        logic cnt_lt_len;
        logic chk_match;
        logic tx_done;
        logic len_zero;
        logic tick_expire;
        logic div_busy;
    } t_sts;

    // Id with the two LIN parity bits on top
    function automatic logic [BYTE_W-1:0] protect_id(input logic [ID_W-1:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // Checksum accumulate, kept mod 255
    function automatic logic [BYTE_W-1:0] add_mod255(input logic [BYTE_W-1:0] acc,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, acc} + {1'b0, b};
        if (s >= {1'b0, SUM_MOD}) begin
            s = s - {1'b0, SUM_MOD};
        end
        return s[BYTE_W-1:0];
    endfunction

endpackage

@@ sv/lsfe_dp.sv @@
// lsfe_dp: datapath of the LIN slave frame engine: checksum, counters,
// tick timer, serial timeout divider, baud register and result value.
// Depends on lsfe_pkg.
module lsfe_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lsfe_pkg::t_cmd                   i_cmd,
    output lsfe_pkg::t_sts                   o_sts,
    input  logic                             i_cfg_we,
    input  logic [lsfe_pkg::BAUD_W-1:0]      i_cfg_baud_rate,
    input  logic [lsfe_pkg::BYTE_W-1:0]      i_byte_value,
    input  logic [lsfe_pkg::ID_W-1:0]        i_frame_id,
    input  logic [lsfe_pkg::LEN_W-1:0]       i_frame_len,
    output logic [lsfe_pkg::BYTE_W-1:0]      o_result_value
);

    localparam int CNT_W = $clog2(lsfe_pkg::NUM_W + 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(lsfe_pkg::NUM_W);
    localparam logic [lsfe_pkg::NUM_W-1:0] Q_SAT =
        lsfe_pkg::NUM_W'(lsfe_pkg::TO_MAX - lsfe_pkg::TO_BASE);

    logic [lsfe_pkg::BAUD_W-1:0] r_baud;
    logic                        r_sync;
    logic [lsfe_pkg::BYTE_W-1:0] r_sum;
    logic [lsfe_pkg::LEN_W-1:0]  r_cnt;
    logic [lsfe_pkg::LEN_W-1:0]  r_len;
    logic [lsfe_pkg::TICK_W-1:0] r_elapsed;
    logic [lsfe_pkg::TICK_W-1:0] r_limit;
    logic [lsfe_pkg::NUM_W-1:0]  r_quo;
    logic [lsfe_pkg::BAUD_W-1:0] r_rem;
    logic [CNT_W-1:0]            r_div_cnt;
    logic [lsfe_pkg::BYTE_W-1:0] r_value;

    logic [lsfe_pkg::LEN_W-1:0]  len_sat;
    logic [lsfe_pkg::BYTE_W-1:0] seed_raw;
    logic [lsfe_pkg::BYTE_W-1:0] seed;
    logic [lsfe_pkg::BYTE_W-1:0] chk;
    logic [lsfe_pkg::LEN_W:0]    cnt_inc;
    logic [lsfe_pkg::TICK_W-1:0] elapsed_nxt;
    logic [lsfe_pkg::BAUD_W-1:0] divisor;
    logic [lsfe_pkg::BAUD_W:0]   rem_sh;
    logic [lsfe_pkg::BAUD_W:0]   rem_diff;
    logic                        q_bit;
    logic [lsfe_pkg::NUM_W-1:0]  quo_nxt;
    logic [lsfe_pkg::TICK_W-1:0] limit_nxt;
    logic [lsfe_pkg::NUM_W-1:0]  numer;
    logic [lsfe_pkg::BYTE_W-1:0] n_value;

    // Arm-time values
    assign len_sat  = (i_frame_len > lsfe_pkg::MAX_DATA_BYTES) ? lsfe_pkg::MAX_DATA_BYTES
                                                               : i_frame_len;
    assign seed_raw = lsfe_pkg::protect_id(i_frame_id);
    assign seed     = (seed_raw == lsfe_pkg::SUM_MOD) ? '0 : seed_raw;
    assign numer    = lsfe_pkg::NUM_W'(len_sat) * lsfe_pkg::LEN_SCALE;

    // Checksum and counters
    assign chk         = ~r_sum;
    assign cnt_inc     = {1'b0, r_cnt} + 1'b1;
    assign elapsed_nxt = (r_elapsed < lsfe_pkg::TO_MAX) ? r_elapsed + 1'b1 : r_elapsed;

    // One restoring division step per cycle
    assign divisor  = (r_baud == '0) ? lsfe_pkg::BAUD_W'(1) : r_baud;
    assign rem_sh   = {r_rem, r_quo[lsfe_pkg::NUM_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, divisor});
    assign rem_diff = q_bit ? (rem_sh - {1'b0, divisor}) : rem_sh;
    assign quo_nxt  = {r_quo[lsfe_pkg::NUM_W-2:0], q_bit};
    assign limit_nxt = (quo_nxt > Q_SAT) ? lsfe_pkg::TO_MAX
                                         : quo_nxt[lsfe_pkg::TICK_W-1:0] + lsfe_pkg::TO_BASE;

    // Result value source
    always_comb begin
        case (i_cmd.out_sel)
            lsfe_pkg::VAL_ID:   n_value = i_byte_value & lsfe_pkg::ID_MASK;
            lsfe_pkg::VAL_BYTE: n_value = i_byte_value;
            lsfe_pkg::VAL_CHK:  n_value = chk;
            default:            n_value = '0;
        endcase
    end

    // Status to controller
    assign o_sts.sync_seen    = r_sync;
    assign o_sts.byte_is_sync = (i_byte_value == lsfe_pkg::SYNC_BYTE);
    assign o_sts.cnt_lt_len   = (r_cnt < r_len);
    assign o_sts.chk_match    = (chk == i_byte_value);
    assign o_sts.tx_done      = (cnt_inc >= {1'b0, r_len});
    assign o_sts.len_zero     = (len_sat == '0);
    assign o_sts.tick_expire  = (elapsed_nxt > r_limit);
    assign o_sts.div_busy     = (r_div_cnt != '0);

    assign o_result_value = r_value;

    // Frame state and divider registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baud    <= lsfe_pkg::BAUD_RESET;
            r_sync    <= 1'b0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_len     <= '0;
            r_elapsed <= '0;
            r_limit   <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_baud <= i_cfg_baud_rate;
            end
            if (i_cmd.hunt_set) begin
                r_sync <= 1'b1;
            end else if (i_cmd.hunt_clr || i_cmd.arm) begin
                r_sync <= 1'b0;
            end
            if (i_cmd.arm) begin
                r_sum     <= seed;
                r_cnt     <= '0;
                r_len     <= len_sat;
                r_elapsed <= '0;
            end else if (i_cmd.add_byte) begin
                r_sum <= lsfe_pkg::add_mod255(r_sum, i_byte_value);
                r_cnt <= cnt_inc[lsfe_pkg::LEN_W-1:0];
            end else if (i_cmd.tick) begin
                r_elapsed <= elapsed_nxt;
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= DIV_STEPS;
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - 1'b1;
                if (r_div_cnt == CNT_W'(1)) begin
                    r_limit <= limit_nxt;
                end
            end
        end
    end

    // Divider operands and result value, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= numer;
            r_rem <= '0;
        end else if (r_div_cnt != '0) begin
            r_quo <= quo_nxt;
            r_rem <= rem_diff[lsfe_pkg::BAUD_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_value <= n_value;
        end
    end

endmodule

@@ sv/lsfe_ctrl.sv @@
// lsfe_ctrl: controller of the LIN slave frame engine: opcode decode,
// frame mode, sequencing and the result valid/kind/last register.
// Depends on lsfe_pkg.
module lsfe_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lsfe_pkg::OPCODE_W-1:0] i_opcode,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lsfe_pkg::KIND_W-1:0]   o_result_kind,
    output logic                          o_is_last,
    output lsfe_pkg::t_cmd                o_cmd,
    input  lsfe_pkg::t_sts                i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_TAIL
    } t_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_RX,
        M_TX
    } t_mode;

    t_state                        r_state, n_state;
    t_mode                         r_mode, n_mode;
    logic                          r_out_valid, n_out_valid;
    logic [lsfe_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic                          r_last, n_last;

    logic out_free;
    logic in_acc;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_is_last     = r_last;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_last      = r_last;
        o_cmd       = '0;
        o_cmd.out_sel = lsfe_pkg::VAL_ZERO;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_opcode)
                        lsfe_pkg::OP_BUS_BYTE: begin
                            if (r_mode == M_IDLE) begin
                                if (i_sts.sync_seen) begin
                                    o_cmd.hunt_clr = 1'b1;
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.out_sel  = lsfe_pkg::VAL_ID;
                                    n_out_valid    = 1'b1;
                                    n_kind         = lsfe_pkg::KIND_HEADER_ID;
                                    n_last         = 1'b1;
                                end else if (i_sts.byte_is_sync) begin
                                    o_cmd.hunt_set = 1'b1;
                                end
                            end else if (r_mode == M_RX) begin
                                o_cmd.out_load = 1'b1;
                                n_out_valid    = 1'b1;
                                n_last         = 1'b1;
                                if (i_sts.cnt_lt_len) begin
                                    o_cmd.add_byte = 1'b1;
                                    o_cmd.out_sel  = lsfe_pkg::VAL_BYTE;
                                    n_kind         = lsfe_pkg::KIND_RX_DATA;
                                end else begin
                                    // trailing checksum byte closes the frame
                                    n_mode        = M_IDLE;
                                    o_cmd.out_sel = lsfe_pkg::VAL_CHK;
                                    n_kind        = i_sts.chk_match ? lsfe_pkg::KIND_FRAME_OK
                                                                    : lsfe_pkg::KIND_CHK_BAD;
                                end
                            end
                        end
                        lsfe_pkg::OP_TICK: begin
                            if (r_mode == M_RX) begin
                                o_cmd.tick = 1'b1;
                                if (i_sts.tick_expire) begin
                                    n_mode         = M_IDLE;
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.out_sel  = lsfe_pkg::VAL_ZERO;
                                    n_out_valid    = 1'b1;
                                    n_kind         = lsfe_pkg::KIND_TIMEOUT;
                                    n_last         = 1'b1;
                                end
                            end
                        end
                        lsfe_pkg::OP_ARM_RX: begin
                            o_cmd.arm       = 1'b1;
                            o_cmd.div_start = 1'b1;
                            n_mode          = M_RX;
                            n_state         = S_DIV;
                        end
                        lsfe_pkg::OP_ARM_TX: begin
                            o_cmd.arm = 1'b1;
                            n_mode    = M_TX;
                            if (i_sts.len_zero) begin
                                // empty response: checksum goes out right away
                                n_mode  = M_IDLE;
                                n_state = S_TAIL;
                            end
                        end
                        lsfe_pkg::OP_TX_DATA: begin
                            if (r_mode == M_TX) begin
                                o_cmd.add_byte = 1'b1;
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_sel  = lsfe_pkg::VAL_BYTE;
                                n_out_valid    = 1'b1;
                                n_kind         = lsfe_pkg::KIND_TX_BYTE;
                                n_last         = !i_sts.tx_done;
                                if (i_sts.tx_done) begin
                                    n_mode  = M_IDLE;
                                    n_state = S_TAIL;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_TAIL: begin
                // append checksum once the output register frees up
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = lsfe_pkg::VAL_CHK;
                    n_out_valid    = 1'b1;
                    n_kind         = lsfe_pkg::KIND_TX_BYTE;
                    n_last         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_IDLE;
            r_out_valid <= 1'b0;
            r_kind      <= lsfe_pkg::KIND_HEADER_ID;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
            r_kind      <= n_kind;
            r_last      <= n_last;
        end
    end

endmodule

@@ sv/lin_slave_frame_engine.sv @@
// lin_slave_frame_engine: LIN slave frame engine top level.
// Instantiates lsfe_ctrl and lsfe_dp; depends on lsfe_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per
//   transaction: bus byte, millisecond tick, arm receive, arm transmit or
//   transmit data byte. Output channel (o_out_valid / i_out_ready) returns
//   result transactions (kind, value, last flag), at most two per input.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the baud rate; it is
//   always ready; it must be written only while the engine is idle, which
//   the block itself does not enforce.
// Sequencing:
//   Most results are registered and valid the cycle after acceptance. Arm
//   receive holds off input until the 17-step bit-serial divider for the
//   timeout limit is done. The last transmit data byte also returns the checksum.
// Stalls and reset:
//   A single output register holds the pending result; a new input is taken
//   in the cycle that result is taken, so a stalled receiver stalls input.
//   Synchronous active-low reset returns to idle hunting for sync, baud
//   rate 19200, output empty.
module lin_slave_frame_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lsfe_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [lsfe_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [lsfe_pkg::ID_W-1:0]     i_frame_id,
    input  logic [lsfe_pkg::LEN_W-1:0]    i_frame_len,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lsfe_pkg::KIND_W-1:0]   o_result_kind,
    output logic [lsfe_pkg::BYTE_W-1:0]   o_result_value,
    output logic                          o_is_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lsfe_pkg::BAUD_W-1:0]   i_cfg_baud_rate
);

    lsfe_pkg::t_cmd cmd;
    lsfe_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    lsfe_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_is_last     (o_is_last),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    lsfe_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_baud_rate (i_cfg_baud_rate),
        .i_byte_value    (i_byte_value),
        .i_frame_id      (i_frame_id),
        .i_frame_len     (i_frame_len),
        .o_result_value  (o_result_value)
    );

endmodule

@@ sv/lsfe_chk.sv @@
// lsfe_chk: port-level assertions for lin_slave_frame_engine, attached by
// the bind statement at the end. Depends on lsfe_pkg.
module lsfe_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [lsfe_pkg::OPCODE_W-1:0] i_opcode,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [lsfe_pkg::KIND_W-1:0]   o_result_kind,
    input logic [lsfe_pkg::BYTE_W-1:0]   o_result_value,
    input logic                          o_is_last
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_value) && $stable(o_result_kind)
            && $stable(o_is_last))
        else $error("stalled result changed");

    // No new input while a result is stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while output stalled");

    // Only a transmit data byte is followed by a second result
    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_last |-> o_result_kind == lsfe_pkg::KIND_TX_BYTE)
        else $error("non-last result of wrong kind");

    // Unknown opcodes produce nothing
    a_unknown_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid && (i_opcode > lsfe_pkg::OP_TX_DATA)
            |=> !o_out_valid)
        else $error("result from unknown opcode");

endmodule

bind lin_slave_frame_engine lsfe_chk u_lsfe_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_opcode       (i_opcode),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_kind  (o_result_kind),
    .o_result_value (o_result_value),
    .o_is_last      (o_is_last)
);

@@ tb/lin_slave_frame_engine_tb.sv @@
// lin_slave_frame_engine_tb: self-checking testbench for the LIN slave frame engine.
// Random and directed frames go through a valid/ready driver; an in-bench model predicts
// each result transaction. Depends on lsfe_pkg and lin_slave_frame_engine.
module lin_slave_frame_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsfe_pkg::*;

    localparam int IDLE_PCT    = 23;
    localparam int SETTLE_CYC  = 32;    // arm receive gives no result while its divider runs
    localparam int HOLD_CYC    = 300;
    localparam int STUCK_LIMIT = 4000;
    localparam int PHASE_ITEMS = 100;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_RX,
        LINK_TX
    } link_mode_e;

    typedef enum logic [1:0] {
        STEP_OP,
        STEP_BAUD,
        STEP_WAIT
    } step_kind_e;

    typedef struct {
        step_kind_e              what;
        logic [OPCODE_W-1:0]     op;
        logic [BYTE_W-1:0]       bv;
        logic [ID_W-1:0]         id;
        logic [LEN_W-1:0]        len;
        logic [BAUD_W-1:0]       rate;
    } bus_step_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } lin_result_t;

    // DUT ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [OPCODE_W-1:0] i_opcode = '0;
    logic [BYTE_W-1:0]   i_byte_value = '0;
    logic [ID_W-1:0]     i_frame_id = '0;
    logic [LEN_W-1:0]    i_frame_len = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [KIND_W-1:0]   o_result_kind;
    logic [BYTE_W-1:0]   o_result_value;
    logic                o_is_last;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [BAUD_W-1:0]   i_cfg_baud_rate = '0;

    // Frame engine model state
    link_mode_e          link_mode;
    bit                  sync_armed;
    logic [BYTE_W-1:0]   chk_acc;
    logic [LEN_W-1:0]    data_cnt;
    logic [LEN_W-1:0]    data_len;
    logic [TICK_W-1:0]   ms_elapsed;
    logic [TICK_W-1:0]   ms_limit;
    logic [BAUD_W-1:0]   bit_rate;

    bus_step_t           op_backlog[$];
    lin_result_t         due_results[$];
    int                  n_predicted;
    int                  n_predicted_q;
    int                  n_seen;
    int                  n_sent;
    int                  n_planned;
    int                  errors;
    int                  quiet;
    int                  hold_left;
    int                  stuck;
    bit                  hold_done;
    bit                  all_sent;
    bit                  sat_tried;

    lin_slave_frame_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_byte_value    (i_byte_value),
        .i_frame_id      (i_frame_id),
        .i_frame_len     (i_frame_len),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_result_value  (o_result_value),
        .o_is_last       (o_is_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_baud_rate (i_cfg_baud_rate)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Id with parity: P0 over bits 0,1,2,4; P1 inverted over bits 1,3,4,5
    function automatic logic [BYTE_W-1:0] pid_of(input logic [ID_W-1:0] id);
        logic p0;
        logic p1;
        p0 = ^(id & 6'b010111);
        p1 = ~(^(id & 6'b111010));
        return {p1, p0, id};
    endfunction

    // One's-complement style sum, kept in 0..254
    function automatic logic [BYTE_W-1:0] sum255(input logic [BYTE_W-1:0] acc,
                                                 input logic [BYTE_W-1:0] b);
        int unsigned s;
        s = acc + b;
        if (s >= 255) begin
            s = s - 255;
        end
        return s[BYTE_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] clip_len(input logic [LEN_W-1:0] len);
        return (len > MAX_DATA_BYTES) ? MAX_DATA_BYTES : len;
    endfunction

    // Receive timeout in ticks; a zero rate counts as one
    function automatic logic [TICK_W-1:0] rx_tick_limit(input logic [LEN_W-1:0] n,
                                                        input logic [BAUD_W-1:0] rate);
        int unsigned d;
        int unsigned t;
        d = (rate == 0) ? 1 : rate;
        t = TO_BASE + (n * LEN_SCALE) / d;
        return (t > TO_MAX) ? TO_MAX : t[TICK_W-1:0];
    endfunction

    function automatic void expect_result(input logic [KIND_W-1:0] kind,
                                          input logic [BYTE_W-1:0] value, input logic last);
        lin_result_t r;
        r.kind = kind;
        r.value = value;
        r.last = last;
        due_results.push_back(r);
        n_predicted++;
    endfunction

    function automatic void reset_engine_model();
        link_mode = LINK_IDLE;
        sync_armed = 1'b0;
        chk_acc = '0;
        data_cnt = '0;
        data_len = '0;
        ms_elapsed = '0;
        ms_limit = '0;
        bit_rate = BAUD_RESET;
    endfunction

    function automatic void start_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                                        input link_mode_e m);
        link_mode = m;
        sync_armed = 1'b0;
        chk_acc = sum255('0, pid_of(id));
        data_cnt = '0;
        data_len = clip_len(len);
        ms_elapsed = '0;
    endfunction

    // Advance the model by one input transaction and queue its results
    function automatic void advance_engine(input logic [OPCODE_W-1:0] op,
                                           input logic [BYTE_W-1:0] bv,
                                           input logic [ID_W-1:0] id,
                                           input logic [LEN_W-1:0] len);
        logic [BYTE_W-1:0] chk;
        case (op)
            OP_BUS_BYTE: begin
                if (link_mode == LINK_IDLE) begin
                    if (sync_armed) begin
                        sync_armed = 1'b0;
                        expect_result(KIND_HEADER_ID, bv & ID_MASK, 1'b1);
                    end else if (bv == SYNC_BYTE) begin
                        sync_armed = 1'b1;
                    end
                end else if (link_mode == LINK_RX) begin
                    if (data_cnt < data_len) begin
                        chk_acc = sum255(chk_acc, bv);
                        data_cnt = data_cnt + 1'b1;
                        expect_result(KIND_RX_DATA, bv, 1'b1);
                    end else begin
                        chk = ~chk_acc;
                        link_mode = LINK_IDLE;
                        expect_result((chk == bv) ? KIND_FRAME_OK : KIND_CHK_BAD, chk, 1'b1);
                    end
                end
            end
            OP_TICK: begin
                if (link_mode == LINK_RX) begin
                    if (ms_elapsed < TO_MAX) begin
                        ms_elapsed = ms_elapsed + 1'b1;
                    end
                    if (ms_elapsed > ms_limit) begin
                        link_mode = LINK_IDLE;
                        expect_result(KIND_TIMEOUT, '0, 1'b1);
                    end
                end
            end
            OP_ARM_RX: begin
                start_frame(id, len, LINK_RX);
                ms_limit = rx_tick_limit(data_len, bit_rate);
            end
            OP_ARM_TX: begin
                start_frame(id, len, LINK_TX);
                if (data_len == 0) begin
                    link_mode = LINK_IDLE;
                    expect_result(KIND_TX_BYTE, ~chk_acc, 1'b1);
                end
            end
            OP_TX_DATA: begin
                if (link_mode == LINK_TX) begin
                    chk_acc = sum255(chk_acc, bv);
                    data_cnt = data_cnt + 1'b1;
                    if (data_cnt >= data_len) begin
                        link_mode = LINK_IDLE;
                        expect_result(KIND_TX_BYTE, bv, 1'b0);
                        expect_result(KIND_TX_BYTE, ~chk_acc, 1'b1);
                    end else begin
                        expect_result(KIND_TX_BYTE, bv, 1'b1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Stimulus planning
    function automatic void queue_op(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] bv,
                                     input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len);
        bus_step_t s;
        s.what = STEP_OP;
        s.op = op;
        s.bv = bv;
        s.id = id;
        s.len = len;
        s.rate = '0;
        op_backlog.push_back(s);
        n_planned++;
    endfunction

    function automatic void queue_mark(input step_kind_e what, input logic [BAUD_W-1:0] rate);
        bus_step_t s;
        s.what = what;
        s.op = '0;
        s.bv = '0;
        s.id = '0;
        s.len = '0;
        s.rate = rate;
        op_backlog.push_back(s);
    endfunction

    // Filler for fields the operation does not use
    function automatic void queue_bare(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] bv);
        queue_op(op, bv, $urandom_range(63), $urandom_range(15));
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(15, 9);
        end
        return $urandom_range(8);
    endfunction

    // Receive frame: data bytes with stray ticks, then a good, bad or missing checksum
    function automatic void plan_rx(input logic [BAUD_W-1:0] rate);
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  n;
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] d;
        logic [TICK_W-1:0] lim;
        int                tail;
        id = $urandom_range(63);
        len = pick_len();
        n = clip_len(len);
        s = sum255('0, pid_of(id));
        queue_op(OP_ARM_RX, $urandom_range(255), id, len);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                queue_bare(OP_TICK, $urandom_range(255));
            end
            d = $urandom_range(255);
            s = sum255(s, d);
            queue_bare(OP_BUS_BYTE, d);
        end
        tail = $urandom_range(99);
        lim = rx_tick_limit(n, rate);
        if (tail < 60) begin
            queue_bare(OP_BUS_BYTE, ~s);
        end else if (tail < 80) begin
            queue_bare(OP_BUS_BYTE, ~s ^ (8'h01 << $urandom_range(7)));
        end else if (lim < TO_MAX) begin
            repeat (int'(lim) + 1) queue_bare(OP_TICK, $urandom_range(255));
        end else if (!sat_tried) begin
            // elapsed count saturates, so a capped limit never fires
            sat_tried = 1'b1;
            repeat (130) queue_bare(OP_TICK, $urandom_range(255));
            queue_bare(OP_BUS_BYTE, ~s);
        end else begin
            queue_bare(OP_BUS_BYTE, $urandom_range(255));
        end
    endfunction

    // Transmit frame, sometimes cut short or mixed with ignored traffic
    function automatic void plan_tx();
        logic [LEN_W-1:0] len;
        int               n;
        len = pick_len();
        n = clip_len(len);
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(n);
        end
        queue_op(OP_ARM_TX, $urandom_range(255), $urandom_range(63), len);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                queue_bare($urandom_range(1) ? OP_BUS_BYTE : OP_TICK, $urandom_range(255));
            end
            queue_bare(OP_TX_DATA, $urandom_range(255));
        end
    endfunction

    function automatic void plan_frame(input logic [BAUD_W-1:0] rate);
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            if ($urandom_range(1)) begin
                queue_bare(OP_BUS_BYTE, $urandom_range(255));
            end
            queue_bare(OP_BUS_BYTE, SYNC_BYTE);
            queue_bare(OP_BUS_BYTE, $urandom_range(255));
        end else if (r < 55) begin
            plan_rx(rate);
        end else if (r < 85) begin
            plan_tx();
        end else begin
            queue_op($urandom_range(7), $urandom_range(255), $urandom_range(63),
                     $urandom_range(15));
        end
    endfunction

    // Driver: input and config channels, predicts on each accepted transaction
    always @(posedge i_clk) begin
        bus_step_t step;
        bit        nv_in;
        bit        nv_cfg;
        bit        steady;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
            all_sent <= 1'b0;
            n_predicted_q <= 0;
            reset_engine_model();
            quiet = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_engine(i_opcode, i_byte_value, i_frame_id, i_frame_len);
                n_sent++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                bit_rate = i_cfg_baud_rate;
            end
            quiet = (n_predicted == n_seen && !i_in_valid && !i_cfg_valid) ? quiet + 1 : 0;

            nv_in = i_in_valid && !o_in_ready;
            nv_cfg = i_cfg_valid && !o_cfg_ready;
            steady = (n_sent >= 450 && n_sent < 560);
            if (!nv_in && !nv_cfg && op_backlog.size() != 0) begin
                step = op_backlog[0];
                case (step.what)
                    STEP_OP: begin
                        if (steady || $urandom_range(99) >= IDLE_PCT) begin
                            step = op_backlog.pop_front();
                            i_opcode <= step.op;
                            i_byte_value <= step.bv;
                            i_frame_id <= step.id;
                            i_frame_len <= step.len;
                            nv_in = 1'b1;
                        end
                    end
                    STEP_BAUD: begin
                        if (quiet >= SETTLE_CYC) begin
                            step = op_backlog.pop_front();
                            i_cfg_baud_rate <= step.rate;
                            nv_cfg = 1'b1;
                        end
                    end
                    default: begin
                        // hold until every outstanding result is back
                        if (n_predicted == n_seen) begin
                            step = op_backlog.pop_front();
                        end
                    end
                endcase
            end
            i_in_valid <= nv_in;
            i_cfg_valid <= nv_cfg;
            all_sent <= (op_backlog.size() == 0) && !nv_in && !nv_cfg;
            n_predicted_q <= n_predicted;
        end
    end

    // Monitor: output channel, one long hold-off to back up the input
    always @(posedge i_clk) begin
        lin_result_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            n_seen <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: expected none, got kind %0d value %02h last %0d",
                             $time, o_result_kind, o_result_value, o_is_last);
                end else begin
                    want = due_results.pop_front();
                    n_seen <= n_seen + 1;
                    if (want.kind !== o_result_kind || want.value !== o_result_value ||
                        want.last !== o_is_last) begin
                        errors++;
                        $display("%0t: expected kind %0d value %02h last %0d, got kind %0d value %02h last %0d",
                                 $time, want.kind, want.value, want.last,
                                 o_result_kind, o_result_value, o_is_last);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && n_seen >= 120 && i_in_valid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYC;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (n_seen >= 250 && n_seen < 330) || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck <= 0;
        end else if (stuck >= STUCK_LIMIT) begin
            $display("lin_slave_frame_engine: mismatch");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    // Stimulus plan, reset and end of run
    initial begin
        logic [BAUD_W-1:0] rate;
        int                phase_start;

        // Directed: headers at the id extremes, ignored operations
        queue_bare(OP_BUS_BYTE, 8'h54);
        queue_bare(OP_BUS_BYTE, SYNC_BYTE);
        queue_bare(OP_BUS_BYTE, 8'hFF);
        queue_bare(OP_BUS_BYTE, SYNC_BYTE);
        queue_bare(OP_BUS_BYTE, 8'h00);
        queue_bare(OP_TICK, 8'h00);
        queue_bare(OP_TX_DATA, 8'hFF);
        queue_op(3'd5, 8'h55, 6'h3F, 4'hF);
        queue_op(3'd6, 8'hAA, 6'h00, 4'h0);
        queue_op(3'd7, 8'h00, 6'h2A, 4'h8);
        // Receive with good checksum, then a zero-length one with a bad checksum
        queue_op(OP_ARM_RX, 8'h00, 6'h3F, 4'd2);
        queue_bare(OP_BUS_BYTE, 8'h00);
        queue_bare(OP_BUS_BYTE, 8'hFF);
        queue_bare(OP_BUS_BYTE, ~sum255(sum255(sum255('0, pid_of(6'h3F)), 8'h00), 8'hFF));
        queue_op(OP_ARM_RX, 8'hFF, 6'h15, 4'd0);
        queue_bare(OP_BUS_BYTE, 8'h00);
        // Zero-length transmit, a one-byte transmit, and a transmit cut by an arm
        queue_op(OP_ARM_TX, 8'h00, 6'h3F, 4'd0);
        queue_op(OP_ARM_TX, 8'h00, 6'h01, 4'd1);
        queue_bare(OP_TX_DATA, 8'hA5);
        queue_op(OP_ARM_TX, 8'h00, 6'h00, 4'hF);
        queue_bare(OP_BUS_BYTE, SYNC_BYTE);
        queue_bare(OP_TX_DATA, 8'h5A);
        // Receive that times out
        queue_op(OP_ARM_RX, 8'h00, 6'h05, 4'd1);
        repeat (6) queue_bare(OP_TICK, 8'h00);

        // Random phases, each behind a baud rate write
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: rate = '0;
                1: rate = 15'h7FFF;
                2: rate = 15'd1000;
                3: rate = 15'd20000;
                4: rate = 15'd1;
                7: rate = BAUD_RESET;
                default: rate = $urandom_range(20000, 1000);
            endcase
            queue_mark(STEP_BAUD, rate);
            phase_start = n_planned;
            while (n_planned - phase_start < PHASE_ITEMS) begin
                if (p == 3 && n_planned - phase_start >= PHASE_ITEMS / 2 &&
                    op_backlog[$].what != STEP_WAIT) begin
                    queue_mark(STEP_WAIT, '0);
                end
                plan_frame(rate);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (!(all_sent && n_predicted_q == n_seen));
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (due_results.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, due_results.size());
        end
        if (errors == 0) begin
            $display("lin_slave_frame_engine: match");
        end else begin
            $display("lin_slave_frame_engine: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/lsfe_pkg.sv
sv/lsfe_dp.sv
sv/lsfe_ctrl.sv
sv/lin_slave_frame_engine.sv
sv/lsfe_chk.sv
tb/lin_slave_frame_engine_tb.sv
